[design/capacitive_presence_detector_defines.svh]
// Assertion macros used by the top-level design file.
`ifndef CAPACITIVE_PRESENCE_DETECTOR_DEFINES_SVH
`define CAPACITIVE_PRESENCE_DETECTOR_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CPD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cpd assertion failed");

// Check cons in the cycle after ante.
`define CPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cpd assertion failed");

`endif

[design/cpd_pkg.sv]
package cpd_pkg;

    localparam int CNT_W_DEFAULT = 15;
    localparam int THR_W         = 15;
    localparam int HOLD_W        = 8;
    localparam int CALIB_W       = 7;
    localparam int CALIB_LEFT_W  = 8;
    localparam int CFG_DATA_W    = 15;
    localparam int REG_IDX_W     = 2;

    localparam logic [THR_W-1:0]   RST_THRESHOLD = 15'd40;
    localparam logic [HOLD_W-1:0]  RST_HOLD      = 8'd100;
    localparam logic [CALIB_W-1:0] RST_CALIB     = 7'd50;
    localparam logic [THR_W-1:0]   RST_BAR_TOP   = 15'd150;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_HOLD      = 2'd1,
        REG_CALIB     = 2'd2,
        REG_BAR_TOP   = 2'd3
    } cpd_reg_e_t;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [HOLD_W-1:0]  hold_samples;
        logic [CALIB_W-1:0] calib_samples;
        logic [THR_W-1:0]   bar_top;
    } cpd_cfg_t;

    typedef struct packed {
        logic emit;
        logic presence;
        logic trigger;
        logic level;
    } cpd_flags_t;

endpackage

[design/cpd_core.sv]
// Baseline tracking, calibration and hold logic; state advances once per step.
module cpd_core
    import cpd_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cpd_cfg_t               cfg,
    input  logic                   calib_restart,
    input  logic [CALIB_W-1:0]     calib_value,
    input  logic                   step_en,
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic                   switch_on,
    output cpd_flags_t             flags,
    output logic [COUNT_WIDTH-1:0] delta
);

    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    logic [COUNT_WIDTH-1:0]  baseline_reg, baseline_next;
    logic [CALIB_LEFT_W-1:0] calib_left_reg, calib_left_next;
    logic                    enabled_reg, enabled_next;
    logic [HOLD_W-1:0]       hold_reg, hold_next;
    logic                    trig_reg, trig_next;
    logic                    level_reg, level_next;

    logic [CALIB_LEFT_W-1:0] calib_reload;
    logic [COUNT_WIDTH:0]    sum;
    logic [COUNT_WIDTH-1:0]  avg;
    logic                    calib_active;
    logic                    detect;
    logic [HOLD_W-1:0]       hold_dec;

    assign calib_reload = {1'b0, cfg.calib_samples} + 8'd1;
    assign sum          = {1'b0, baseline_reg} + {1'b0, count};
    assign avg          = sum[COUNT_WIDTH:1];
    assign calib_active = (calib_left_reg != '0);
    assign enabled_next = enabled_reg | switch_on;
    assign hold_dec     = (hold_reg != '0) ? hold_reg - 8'd1 : hold_reg;

    always_comb begin
        baseline_next   = baseline_reg;
        calib_left_next = calib_left_reg;
        delta           = '0;
        if (calib_active) begin
            baseline_next   = (calib_left_reg == calib_reload) ? count : avg;
            calib_left_next = calib_left_reg - 8'd1;
        end else if (enabled_next) begin
            if (count > baseline_reg) begin
                baseline_next = avg;
            end else begin
                delta = baseline_reg - count;
            end
        end
    end

    assign detect = (CMP_W'(delta) > CMP_W'(cfg.threshold));

    always_comb begin
        flags.emit = !calib_active && enabled_next;
        if (detect) begin
            hold_next      = cfg.hold_samples;
            trig_next      = 1'b1;
            level_next     = (CMP_W'(delta) >= CMP_W'(cfg.bar_top));
            flags.presence = 1'b1;
        end else begin
            hold_next      = hold_dec;
            trig_next      = trig_reg;
            level_next     = level_reg;
            flags.presence = (hold_dec != '0);
        end
        flags.trigger = trig_next;
        flags.level   = level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg   <= '0;
            calib_left_reg <= {1'b0, RST_CALIB} + 8'd1;
            enabled_reg    <= 1'b0;
            hold_reg       <= '0;
            trig_reg       <= 1'b0;
            level_reg      <= 1'b0;
        end else if (calib_restart) begin
            // Reload from the value being written, not the old register.
            calib_left_reg <= {1'b0, calib_value} + 8'd1;
        end else if (step_en) begin
            baseline_reg   <= baseline_next;
            calib_left_reg <= calib_left_next;
            enabled_reg    <= enabled_next;
            // Detector state only moves on items that give a result.
            if (flags.emit) begin
                hold_reg  <= hold_next;
                trig_reg  <= trig_next;
                level_reg <= level_next;
            end
        end
    end

endmodule

[design/capacitive_presence_detector.sv]
// Pipeline: a count accepted into the input stage moves to the result stage once that
// stage is free and is then offered on m_tdata; the whole update sits between the two
// register stages. Throughput: one count per cycle unless m_tready stalls the output.
// Counts used for calibration, or taken before the switch latches enable, give no result.
// Reset: aresetn is synchronous, active low; it loads the register defaults and restarts
// calibration. Writing calib_samples also restarts calibration.
`include "capacitive_presence_detector_defines.svh"

module capacitive_presence_detector
    import cpd_pkg::*;
#(
    parameter int COUNT_WIDTH = CNT_W_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [REG_IDX_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // Count stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((COUNT_WIDTH+7)/8)*8-1:0] s_tdata,  // meas_count, zero pad
    input  logic                         s_tuser,  // switch_on
    // Result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // presence, trigger_out, fast_scan, delta, level_high, zero pad
    output logic [((COUNT_WIDTH+4+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W  = ((COUNT_WIDTH + 4 + 7) / 8) * 8;
    localparam int CMP_W  = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
    localparam int PAD_W  = OUT_W - COUNT_WIDTH - 4;

    // ---------------- configuration registers ----------------
    cpd_cfg_t cfg_reg;
    logic     calib_restart;

    assign cfg_ready     = 1'b1;
    assign calib_restart = cfg_valid && (cfg_addr == REG_CALIB);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold     <= RST_THRESHOLD;
            cfg_reg.hold_samples  <= RST_HOLD;
            cfg_reg.calib_samples <= RST_CALIB;
            cfg_reg.bar_top       <= RST_BAR_TOP;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_THRESHOLD: cfg_reg.threshold     <= cfg_data[THR_W-1:0];
                REG_HOLD:      cfg_reg.hold_samples  <= cfg_data[HOLD_W-1:0];
                REG_CALIB:     cfg_reg.calib_samples <= cfg_data[CALIB_W-1:0];
                REG_BAR_TOP:   cfg_reg.bar_top       <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    // The input stage frees up whenever the result stage can take its item,
    // so a new count is accepted into an empty input stage while a finished result still waits.
    logic                   in_v_reg, in_v_next;
    logic [COUNT_WIDTH-1:0] in_count_reg;
    logic                   in_sw_reg;
    logic                   out_free;
    logic                   advance;
    logic                   s_accept;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_v_reg && out_free;
    assign s_tready = !in_v_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_v_next = 1'b1;
        end else if (advance) begin
            in_v_next = 1'b0;
        end else begin
            in_v_next = in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else begin
            in_v_reg <= in_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_count_reg <= s_tdata[COUNT_WIDTH-1:0];
            in_sw_reg    <= s_tuser;
        end
    end

    // ---------------- detector core ----------------
    cpd_flags_t             flags;
    logic [COUNT_WIDTH-1:0] delta;

    cpd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .calib_restart (calib_restart),
        .calib_value   (cfg_data[CALIB_W-1:0]),
        .step_en       (advance),
        .count         (in_count_reg),
        .switch_on     (in_sw_reg),
        .flags         (flags),
        .delta         (delta)
    );

    // ---------------- result stage ----------------
    // Load a result only for counts that give one; drop the slot once taken.
    logic                   out_v_reg, out_v_next;
    logic                   out_pres_reg;
    logic                   out_trig_reg;
    logic                   out_level_reg;
    logic [COUNT_WIDTH-1:0] out_delta_reg;

    always_comb begin
        if (advance) begin
            out_v_next = flags.emit;
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end else begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && flags.emit) begin
            out_pres_reg  <= flags.presence;
            out_trig_reg  <= flags.trigger;
            out_level_reg <= flags.level;
            out_delta_reg <= delta;
        end
    end

    assign m_tvalid = out_v_reg;
    // fast_scan follows presence: fast scan while someone is near or in hold.
    assign m_tdata  = {{PAD_W{1'b0}}, out_level_reg, out_delta_reg,
                       out_pres_reg, out_trig_reg, out_pres_reg};

    // ---------------- assertions ----------------
    logic out_detect;
    logic out_level_ok;
    logic in_stall;

    assign out_detect   = out_v_reg && (CMP_W'(out_delta_reg) > CMP_W'(cfg_reg.threshold));
    assign out_level_ok = (out_level_reg == (CMP_W'(out_delta_reg) >= CMP_W'(cfg_reg.bar_top)));
    assign in_stall     = in_v_reg && !out_free;

    // Hold a stalled count in the input stage.
    `CPD_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_stall, in_v_reg && $stable(in_count_reg))
    // A delta above threshold must show presence and the latched trigger.
    `CPD_ASSERT_SAME(a_detect_flags, aclk, aresetn, out_detect, out_pres_reg && out_trig_reg)
    // On a detection the level LED tracks delta against bar_top.
    `CPD_ASSERT_SAME(a_level, aclk, aresetn, out_detect, out_level_ok)

endmodule
